>>> design/evd_pkg.sv
// evd_pkg: shared types and constants for the EDF-VD schedulability check
// no dependencies
`default_nettype none
package evd_pkg;
   localparam int EVD_LEVELS_DEF = 4;
   localparam int SUM_W          = 24;
   localparam int VAL_W          = 17;
   localparam int X_W            = 32;
   localparam int CORE_W         = 4;
   localparam int LVL_W          = 2;
   localparam logic [VAL_W-1:0] ONE_Q16 = 17'h10000;
   localparam logic [SUM_W-1:0] SUM_MAX = 24'hFFFFFF;
   localparam logic [X_W-1:0]   X_MAX   = 32'hFFFFFFFF;
   localparam int DIV_STEPS = X_W + 1;
   localparam int DCNT_W    = 6;

   typedef enum logic [1:0] {
      VERDICT_INFEAS  = 2'd0,
      VERDICT_EDF     = 2'd1,
      VERDICT_VD      = 2'd2,
      VERDICT_UNSCHED = 2'd3
   } verdict_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_SWEEP, ST_CHECK, ST_K_READ, ST_K_MUL1, ST_K_MUL2,
      ST_K_CMP, ST_DIV, ST_DONE
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic        acc;
      logic        init;
      logic        sweep;
      logic        k_read;
      logic        mul1;
      logic        mul2;
      logic        k_next;
      logic        div_init;
      logic        div_step;
      logic        emit;
      verdict_type verdict;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic sweep_end;
      logic fail;
      logic diag_ok;
      logic skip;
      logic pass;
      logic k_last;
      logic div_done;
   } status_type;
endpackage
`default_nettype wire

>>> design/edf_vd_schedulability_check.sv
// edf_vd_schedulability_check: top level joining controller and datapath
// depends on evd_pkg, evd_ctrl, evd_dp
//
// channel   dir  handshake              payload
// request   in   start & !busy          req_task_level/core, req_util_level/value, req_last_item
// result    out  rsp_valid (1 cycle)    rsp_verdict, rsp_scale, rsp_switch_level
// csr       in   csr_valid & csr_ready  csr_data (core select)
//
// a request without last item is only accumulated; busy stays low
// a last-item request runs the test: a sweep of the matrix, one check, then per level
// tried a read, two multiplies and a compare (only the read and first multiply for a
// skipped level), the divider when a level passes, and the result state
// synchronous reset clears the matrix, core select and control; csr is always ready
// the receiver cannot stall; the result is shown for one cycle only
`default_nettype none
module edf_vd_schedulability_check #(
   parameter int LEVELS = evd_pkg::EVD_LEVELS_DEF
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   output logic                            busy,
   input  wire logic [evd_pkg::LVL_W-1:0]  req_task_level,
   input  wire logic [evd_pkg::CORE_W-1:0] req_task_core,
   input  wire logic [evd_pkg::LVL_W-1:0]  req_util_level,
   input  wire logic [evd_pkg::VAL_W-1:0]  req_util_value,
   input  wire logic                       req_last_item,
   output logic                            rsp_valid,
   output logic [1:0]                      rsp_verdict,
   output logic [evd_pkg::X_W-1:0]         rsp_scale,
   output logic [evd_pkg::LVL_W-1:0]       rsp_switch_level,
   input  wire logic                       csr_valid,
   output logic                            csr_ready,
   input  wire logic [evd_pkg::CORE_W-1:0] csr_data
);
   import evd_pkg::*;

   cmd_type    cmd;
   status_type status;

   assign csr_ready = 1'b1;

   // sequencing
   evd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .last_item (req_last_item),
      .busy      (busy),
      .cmd       (cmd),
      .status    (status)
   );

   // matrix and arithmetic
   evd_dp #(.LEVELS(LEVELS)) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_task_level   (req_task_level),
      .req_task_core    (req_task_core),
      .req_util_level   (req_util_level),
      .req_util_value   (req_util_value),
      .csr_valid        (csr_valid),
      .csr_data         (csr_data),
      .rsp_valid        (rsp_valid),
      .rsp_verdict      (rsp_verdict),
      .rsp_scale        (rsp_scale),
      .rsp_switch_level (rsp_switch_level)
   );
endmodule
`default_nettype wire

>>> design/evd_dp.sv
// evd_dp: utilisation matrix, test sums, multiplier and shift-subtract divider
// depends on evd_pkg
`default_nettype none
module evd_dp #(
   parameter int LEVELS = evd_pkg::EVD_LEVELS_DEF
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire evd_pkg::cmd_type           cmd,
   output evd_pkg::status_type             status,
   input  wire logic [evd_pkg::LVL_W-1:0]  req_task_level,
   input  wire logic [evd_pkg::CORE_W-1:0] req_task_core,
   input  wire logic [evd_pkg::LVL_W-1:0]  req_util_level,
   input  wire logic [evd_pkg::VAL_W-1:0]  req_util_value,
   input  wire logic                       csr_valid,
   input  wire logic [evd_pkg::CORE_W-1:0] csr_data,
   output logic                            rsp_valid,
   output logic [1:0]                      rsp_verdict,
   output logic [evd_pkg::X_W-1:0]         rsp_scale,
   output logic [evd_pkg::LVL_W-1:0]       rsp_switch_level
);
   import evd_pkg::*;

   localparam int IDX_W  = (LEVELS > 1) ? $clog2(LEVELS) : 1;
   localparam int ACC_W  = SUM_W + IDX_W;
   localparam int PROD_W = ACC_W + VAL_W + 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(LEVELS - 1);
   localparam logic [IDX_W-1:0] KLAST_IDX = IDX_W'(LEVELS - 2);

   logic [SUM_W-1:0]  mat_ff [LEVELS][LEVELS];
   logic [VAL_W-1:0]  colsum_ff [LEVELS];
   logic [CORE_W-1:0] core_ff;
   logic [IDX_W-1:0]  row_ff, col_ff, k_ff;
   logic [ACC_W-1:0]  colacc_ff, diag_ff, ll_ff, hh_ff;
   logic              fail_ff, skip_ff;
   logic [VAL_W-1:0]  hl_ff, d_ff;
   logic [PROD_W-1:0] prod_ff;
   logic [VAL_W:0]    rem_ff;
   logic [X_W:0]      num_ff;
   logic [DCNT_W-1:0] dcnt_ff;
   logic              rsp_valid_ff;
   verdict_type       verdict_ff;
   logic [X_W-1:0]    x_ff;
   logic [LVL_W-1:0]  k_out_ff;

   logic [IDX_W-1:0]  rd_row, rd_col, in_row, in_col;
   logic [SUM_W-1:0]  rd;
   logic [SUM_W:0]    acc_sum;
   logic              in_hit;
   logic [ACC_W-1:0]  colacc_in, ll_in;
   logic [VAL_W:0]    trial;
   logic [VAL_W:0]    trial_sub;
   logic [PROD_W-1:0] bound;
   logic [2*VAL_W-1:0]      prod_hl;
   logic [ACC_W+VAL_W-1:0]  prod_hh;

   // single read port of the matrix
   assign in_row = IDX_W'(req_task_level);
   assign in_col = IDX_W'(req_util_level);
   always_comb begin
      rd_row = in_row;
      rd_col = in_col;
      if (cmd.sweep) begin
         rd_row = row_ff;
         rd_col = col_ff;
      end else if (cmd.k_read) begin
         rd_row = k_ff;
         rd_col = k_ff;
      end
   end
   assign rd = mat_ff[rd_row][rd_col];

   // accumulate one request with saturation
   assign in_hit = (req_task_core == core_ff) && (32'(req_task_level) < LEVELS)
                   && (32'(req_util_level) < LEVELS);
   assign acc_sum = {1'b0, rd} + (SUM_W+1)'(req_util_value);

   always_ff @(posedge clock) begin
      if (reset || cmd.emit) begin
         for (int r = 0; r < LEVELS; r++)
            for (int c = 0; c < LEVELS; c++)
               mat_ff[r][c] <= '0;
      end else if (cmd.acc && in_hit) begin
         mat_ff[in_row][in_col] <= acc_sum[SUM_W] ? SUM_MAX : acc_sum[SUM_W-1:0];
      end
   end

   // core select register
   always_ff @(posedge clock) begin
      if (reset) begin
         core_ff <= '0;
      end else if (csr_valid) begin
         core_ff <= csr_data;
      end
   end

   // column sums and diagonal sweep
   assign colacc_in = (row_ff == col_ff) ? ACC_W'(rd) : colacc_ff + ACC_W'(rd);
   assign ll_in     = ll_ff + ACC_W'(rd);

   always_ff @(posedge clock) begin
      if (cmd.init) begin
         row_ff  <= '0;
         col_ff  <= '0;
         diag_ff <= '0;
         fail_ff <= 1'b0;
         k_ff    <= '0;
         ll_ff   <= '0;
      end else if (cmd.sweep) begin
         colacc_ff <= colacc_in;
         if (row_ff == col_ff)
            diag_ff <= diag_ff + ACC_W'(rd);
         if (row_ff == LAST_IDX) begin
            // colsum only used when every column passed, so it fits
            colsum_ff[col_ff] <= VAL_W'(colacc_in);
            if (colacc_in > ACC_W'(ONE_Q16))
               fail_ff <= 1'b1;
            col_ff <= col_ff + 1'b1;
            row_ff <= col_ff + 1'b1;
         end else begin
            row_ff <= row_ff + 1'b1;
         end
      end else if (cmd.k_read) begin
         ll_ff   <= ll_in;
         hl_ff   <= colsum_ff[k_ff] - VAL_W'(rd);
         hh_ff   <= diag_ff - ll_in;
         d_ff    <= VAL_W'(ACC_W'(ONE_Q16) - ll_in);
         skip_ff <= ll_in >= ACC_W'(ONE_Q16);
      end else if (cmd.k_next) begin
         k_ff <= k_ff + 1'b1;
      end
   end

   // condition hl*ll + hh*d <= d<<16, one product per cycle
   assign prod_hl = hl_ff * ll_ff[VAL_W-1:0];
   assign prod_hh = hh_ff * d_ff;
   always_ff @(posedge clock) begin
      if (cmd.mul1)
         prod_ff <= PROD_W'(prod_hl);
      else if (cmd.mul2)
         prod_ff <= prod_ff + PROD_W'(prod_hh);
   end
   assign bound = PROD_W'({d_ff, 16'b0});

   // restoring divider, one quotient bit per cycle
   assign trial     = {rem_ff[VAL_W-1:0], num_ff[X_W]};
   assign trial_sub = trial - {1'b0, d_ff};
   always_ff @(posedge clock) begin
      if (reset) begin
         dcnt_ff <= '0;
      end else if (cmd.div_init) begin
         dcnt_ff <= DCNT_W'(DIV_STEPS);
         rem_ff  <= '0;
         num_ff  <= {hl_ff, 16'b0};
      end else if (cmd.div_step) begin
         dcnt_ff <= dcnt_ff - 1'b1;
         if (trial >= {1'b0, d_ff}) begin
            rem_ff <= trial_sub;
            num_ff <= {num_ff[X_W-1:0], 1'b1};
         end else begin
            rem_ff <= trial;
            num_ff <= {num_ff[X_W-1:0], 1'b0};
         end
      end
   end

   // status to the controller
   always_comb begin
      status.sweep_end = (row_ff == LAST_IDX) && (col_ff == LAST_IDX);
      status.fail      = fail_ff;
      status.diag_ok   = diag_ff <= ACC_W'(ONE_Q16);
      status.skip      = skip_ff;
      status.pass      = prod_ff <= bound;
      status.k_last    = k_ff == KLAST_IDX;
      status.div_done  = dcnt_ff == '0;
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset)
         rsp_valid_ff <= 1'b0;
      else
         rsp_valid_ff <= cmd.emit;
   end
   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         verdict_ff <= cmd.verdict;
         case (cmd.verdict)
            VERDICT_EDF: begin
               x_ff     <= X_W'(ONE_Q16);
               k_out_ff <= LVL_W'(LEVELS - 1);
            end
            VERDICT_VD: begin
               x_ff     <= num_ff[X_W] ? X_MAX : num_ff[X_W-1:0];
               k_out_ff <= LVL_W'(k_ff);
            end
            default: begin
               x_ff     <= '0;
               k_out_ff <= '0;
            end
         endcase
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_verdict      = verdict_ff;
   assign rsp_scale        = x_ff;
   assign rsp_switch_level = k_out_ff;
endmodule
`default_nettype wire

>>> design/evd_ctrl.sv
// evd_ctrl: state machine sequencing intake, sweep, per-level test and divide
// depends on evd_pkg
`default_nettype none
module evd_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   input  wire logic                last_item,
   output logic                     busy,
   output evd_pkg::cmd_type         cmd,
   input  wire evd_pkg::status_type status
);
   import evd_pkg::*;

   state_type   state_ff, state_in;
   verdict_type verdict_ff, verdict_in;
   logic        accept;

   assign accept = start && !busy;
   assign busy   = state_ff != ST_IDLE;

   // next state
   always_comb begin
      state_in   = state_ff;
      verdict_in = verdict_ff;
      case (state_ff)
         ST_IDLE:   if (accept && last_item) state_in = ST_SWEEP;
         ST_SWEEP:  if (status.sweep_end) state_in = ST_CHECK;
         ST_CHECK: begin
            if (status.fail) begin
               state_in   = ST_DONE;
               verdict_in = VERDICT_INFEAS;
            end else if (status.diag_ok) begin
               state_in   = ST_DONE;
               verdict_in = VERDICT_EDF;
            end else begin
               state_in = ST_K_READ;
            end
         end
         ST_K_READ: state_in = ST_K_MUL1;
         ST_K_MUL1: begin
            if (!status.skip) begin
               state_in = ST_K_MUL2;
            end else if (status.k_last) begin
               state_in   = ST_DONE;
               verdict_in = VERDICT_UNSCHED;
            end else begin
               state_in = ST_K_READ;
            end
         end
         ST_K_MUL2: state_in = ST_K_CMP;
         ST_K_CMP: begin
            if (status.pass) begin
               state_in = ST_DIV;
            end else if (status.k_last) begin
               state_in   = ST_DONE;
               verdict_in = VERDICT_UNSCHED;
            end else begin
               state_in = ST_K_READ;
            end
         end
         ST_DIV: begin
            if (status.div_done) begin
               state_in   = ST_DONE;
               verdict_in = VERDICT_VD;
            end
         end
         ST_DONE:   state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         verdict_ff <= VERDICT_INFEAS;
      end else begin
         state_ff   <= state_in;
         verdict_ff <= verdict_in;
      end
   end

   // commands
   always_comb begin
      cmd         = '0;
      cmd.verdict = verdict_ff;
      case (state_ff)
         ST_IDLE: begin
            cmd.acc  = accept;
            cmd.init = accept && last_item;
         end
         ST_SWEEP:  cmd.sweep = 1'b1;
         ST_K_READ: cmd.k_read = 1'b1;
         ST_K_MUL1: begin
            cmd.mul1   = 1'b1;
            cmd.k_next = status.skip && !status.k_last;
         end
         ST_K_MUL2: cmd.mul2 = 1'b1;
         ST_K_CMP: begin
            cmd.div_init = status.pass;
            cmd.k_next   = !status.pass && !status.k_last;
         end
         ST_DIV:    cmd.div_step = !status.div_done;
         ST_DONE:   cmd.emit = 1'b1;
         default:   cmd = '0;
      endcase
   end

`ifndef SYNTHESIS
   a_emit_single: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |=> !cmd.emit) else $error("result emitted twice");
   a_last_busy: assert property (@(posedge clock) disable iff (reset)
      (accept && last_item) |=> busy) else $error("last request did not start test");
   a_div_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV && status.div_done) |=> cmd.emit)
      else $error("divide finished without result");
   a_no_acc_busy: assert property (@(posedge clock) disable iff (reset)
      busy |-> !cmd.acc) else $error("accumulate while busy");
`endif
endmodule
`default_nettype wire
